/* rtl/nglm_pkg.sv */
// Shared types and constants for the normalised group level means block.
// Holds the controller-to-datapath command and status structures.
// Depends on nothing.
package nglm_pkg;

  localparam int unsigned NUM_GROUPS = 3;
  localparam int unsigned GRP_W      = 2;

  localparam logic [GRP_W-1:0] GRP_LEFT   = 2'd0;
  localparam logic [GRP_W-1:0] GRP_CENTER = 2'd1;
  localparam logic [GRP_W-1:0] GRP_RIGHT  = 2'd2;

  typedef struct packed {
    logic             capture;
    logic             div_start;
    logic             mean_sel;
    logic             acc_en;
    logic             acc_from_div;
    logic             level_en;
    logic             level_zero;
    logic             clear;
    logic [GRP_W-1:0] grp;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic need_div;
    logic last;
    logic cnt_zero;
    logic div_done;
  } status_t;

endpackage

/* rtl/nglm_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the ratio and the group mean calculations; no package needed.
// The initial partial remainder must be below the divisor.
module nglm_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned QW = 17,
  parameter int unsigned SW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] steps_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] lo_q, lo_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [DW:0]   rem2;
  logic [DW:0]   diff;
  logic          ge;

  assign rem2 = {rem_q, lo_q[QW-1]};
  assign diff = rem2 - {1'b0, dvs_q};
  assign ge   = rem2 >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = rem_i;
      lo_d  = lo_i;
      dvs_d = divisor_i;
      quo_d = '0;
      cnt_d = steps_i;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? diff[DW-1:0] : rem2[DW-1:0];
      lo_d  = {lo_q[QW-2:0], 1'b0};
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == SW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/nglm_datapath.sv */
// Datapath: captured beat, span and offset, group accumulators and means.
// Depends on nglm_pkg for command and status types and on nglm_div.
// Driven entirely by commands from nglm_ctrl.
module nglm_datapath #(
  parameter int unsigned MAX_GROUP_ITEMS = 4096,
  parameter int unsigned SAMPLE_BITS     = 24,
  parameter int unsigned FRAC_BITS       = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nglm_pkg::cmd_t         cmd_i,
  output nglm_pkg::status_t      status_o,
  input  logic                   has_sample_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] low_ref_i,
  input  logic [SAMPLE_BITS-1:0] high_ref_i,
  input  logic [1:0]             group_i,
  input  logic                   last_i,
  output logic [FRAC_BITS:0]     level_left_o,
  output logic [FRAC_BITS:0]     level_center_o,
  output logic [FRAC_BITS:0]     level_right_o
);
  import nglm_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(MAX_GROUP_ITEMS + 1);
  localparam int unsigned SUM_W = QW + $clog2(MAX_GROUP_ITEMS);
  localparam int unsigned DW    = (SB > CNT_W) ? SB : CNT_W;
  localparam int unsigned SW    = $clog2(QW + 1);

  logic                has_q, last_q;
  logic [GRP_W-1:0]    grp_q;
  logic signed [SB:0]  span_q, num_q;
  logic signed [SB:0]  span_d, num_d;
  logic [SUM_W-1:0]    sum_q [NUM_GROUPS];
  logic [CNT_W-1:0]    cnt_q [NUM_GROUPS];
  logic [QW-1:0]       level_q [NUM_GROUPS];
  logic [GRP_W-1:0]    idx, rd_idx;
  logic [SUM_W-1:0]    rd_sum, sum_hi;
  logic [CNT_W-1:0]    rd_cnt;
  logic                grp_ok, pos, full_scale;
  logic [QW-1:0]       add_val, special_val;
  logic [DW-1:0]       div_rem, div_dvs;
  logic [QW-1:0]       div_lo, quo;
  logic [SW-1:0]       div_steps;
  logic                div_done;

  assign span_d = {high_ref_i[SB-1], high_ref_i} - {low_ref_i[SB-1], low_ref_i};
  assign num_d  = {sample_i[SB-1], sample_i} - {low_ref_i[SB-1], low_ref_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      has_q  <= has_sample_i;
      last_q <= last_i;
      grp_q  <= group_i;
      span_q <= span_d;
      num_q  <= num_d;
    end
  end

  assign idx    = cmd_i.mean_sel ? cmd_i.grp : grp_q;
  assign rd_idx = (idx == GRP_RIGHT || idx == GRP_LEFT || idx == GRP_CENTER) ? idx : GRP_RIGHT;
  assign rd_sum = sum_q[rd_idx];
  assign rd_cnt = cnt_q[rd_idx];
  assign sum_hi = rd_sum >> QW;

  assign grp_ok      = (grp_q == GRP_LEFT) || (grp_q == GRP_CENTER) || (grp_q == GRP_RIGHT);
  assign pos         = (span_q > 0) && (num_q > 0);
  assign full_scale  = pos && (num_q >= span_q);
  assign special_val = full_scale ? {1'b1, {FRAC_BITS{1'b0}}} : '0;
  assign add_val     = cmd_i.acc_from_div ? quo : special_val;

  assign status_o.take     = has_q && grp_ok && (rd_cnt < CNT_W'(MAX_GROUP_ITEMS));
  assign status_o.need_div = pos && !full_scale;
  assign status_o.last     = last_q;
  assign status_o.cnt_zero = (rd_cnt == '0);
  assign status_o.div_done = div_done;

  always_comb begin
    if (cmd_i.mean_sel) begin
      div_rem   = DW'(sum_hi);
      div_lo    = rd_sum[QW-1:0];
      div_dvs   = DW'(rd_cnt);
      div_steps = SW'(QW);
    end else begin
      div_rem   = DW'(num_q[SB-1:0]);
      div_lo    = '0;
      div_dvs   = DW'(span_q[SB-1:0]);
      div_steps = SW'(FRAC_BITS);
    end
  end

  nglm_div #(
    .DW(DW),
    .QW(QW),
    .SW(SW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .rem_i    (div_rem),
    .lo_i     (div_lo),
    .divisor_i(div_dvs),
    .steps_i  (div_steps),
    .done_o   (div_done),
    .quo_o    (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        sum_q[g] <= '0;
        cnt_q[g] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        sum_q[g] <= '0;
        cnt_q[g] <= '0;
      end
    end else if (cmd_i.acc_en) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        if (rd_idx == GRP_W'(g)) begin
          sum_q[g] <= sum_q[g] + SUM_W'(add_val);
          cnt_q[g] <= cnt_q[g] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.level_en) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        if (cmd_i.grp == GRP_W'(g)) begin
          level_q[g] <= cmd_i.level_zero ? '0 : quo;
        end
      end
    end
  end

  assign level_left_o   = level_q[GRP_LEFT];
  assign level_center_o = level_q[GRP_CENTER];
  assign level_right_o  = level_q[GRP_RIGHT];

endmodule

/* rtl/nglm_ctrl.sv */
// Controller state machine: sequences capture, ratio divide, accumulation,
// the three group means and the result beat. Depends on nglm_pkg.
module nglm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              valid_o,
  output nglm_pkg::cmd_t    cmd_o,
  input  nglm_pkg::status_t status_i
);
  import nglm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIVR  = 3'd2;
  localparam logic [2:0] S_MSET  = 3'd3;
  localparam logic [2:0] S_MWAIT = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [GRP_W-1:0] k_q, k_d;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.grp = k_q;
    unique case (state_q)
      S_IDLE: begin
        k_d = GRP_LEFT;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.take && status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVR;
        end else begin
          cmd_o.acc_en = status_i.take;
          state_d      = status_i.last ? S_MSET : S_IDLE;
        end
      end
      S_DIVR: begin
        if (status_i.div_done) begin
          cmd_o.acc_en       = 1'b1;
          cmd_o.acc_from_div = 1'b1;
          state_d            = status_i.last ? S_MSET : S_IDLE;
        end
      end
      S_MSET: begin
        cmd_o.mean_sel = 1'b1;
        if (status_i.cnt_zero) begin
          cmd_o.level_en   = 1'b1;
          cmd_o.level_zero = 1'b1;
          k_d              = k_q + GRP_W'(1);
          state_d          = (k_q == GRP_RIGHT) ? S_EMIT : S_MSET;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_MWAIT;
        end
      end
      S_MWAIT: begin
        cmd_o.mean_sel = 1'b1;
        if (status_i.div_done) begin
          cmd_o.level_en = 1'b1;
          k_d            = k_q + GRP_W'(1);
          state_d        = (k_q == GRP_RIGHT) ? S_EMIT : S_MSET;
        end
      end
      S_EMIT: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= GRP_LEFT;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = (state_q == S_EMIT);

`ifndef SYNTHESIS
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_DIVR || state_q == S_MWAIT))
    else $error("Divider finished while the controller was not waiting for it.");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("Result beat lasted more than one cycle.");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_CHECK))
    else $error("Accepted beat did not move the controller to the check state.");

  a_mean_group_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MSET || state_q == S_MWAIT) |-> (k_q != 2'd3))
    else $error("Mean sequence ran past the last group.");
`endif

endmodule

/* rtl/normalized_group_level_means.sv */
// Normalised group level means, top level: nglm_ctrl plus nglm_datapath.
// A pixel beat whose ratio needs the divider waits for the shared divider, which
// yields one quotient bit per cycle; other beats skip the divider.
// A beat with last set then runs the divider for each group mean with a nonzero count.
// The result beat lasts one cycle and cannot be stalled; busy is low after it.
// Reset is asynchronous and active low and clears all sums and counts at once.
module normalized_group_level_means #(
  parameter int unsigned MAX_GROUP_ITEMS = 4096,
  parameter int unsigned SAMPLE_BITS     = 24,
  parameter int unsigned FRAC_BITS       = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   has_sample_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] low_ref_i,
  input  logic [SAMPLE_BITS-1:0] high_ref_i,
  input  logic [1:0]             group_i,
  input  logic                   last_i,
  output logic                   valid_o,
  output logic [FRAC_BITS:0]     level_left_o,
  output logic [FRAC_BITS:0]     level_center_o,
  output logic [FRAC_BITS:0]     level_right_o
);
  import nglm_pkg::*;

  cmd_t    cmd;
  status_t status;

  nglm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd),
    .status_i(status)
  );

  nglm_datapath #(
    .MAX_GROUP_ITEMS(MAX_GROUP_ITEMS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .has_sample_i  (has_sample_i),
    .sample_i      (sample_i),
    .low_ref_i     (low_ref_i),
    .high_ref_i    (high_ref_i),
    .group_i       (group_i),
    .last_i        (last_i),
    .level_left_o  (level_left_o),
    .level_center_o(level_center_o),
    .level_right_o (level_right_o)
  );

endmodule

/* tb/sv/normalized_group_level_means_tb.sv */
// Self-checking testbench for normalized_group_level_means: directed table, full-group
// fill and random batches, each accepted beat predicted in SystemVerilog.
// Depends on nglm_pkg and the normalized_group_level_means RTL only.
module normalized_group_level_means_tb;
  import nglm_pkg::*;

  localparam int unsigned SB        = 24;
  localparam int unsigned FB        = 16;
  localparam int unsigned MAXG      = 4096;
  localparam int unsigned LIMIT     = 1_000_000;
  localparam int unsigned ITEMS     = 800;
  localparam int unsigned IDLE_PCT  = 28;
  localparam logic [1:0]  GRP_UNUSED = 2'd3;
  localparam logic [SB-1:0] S_MIN   = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] S_MAX   = {1'b0, {(SB-1){1'b1}}};
  localparam logic [FB:0]   ONE     = {1'b1, {FB{1'b0}}};

  typedef struct packed {
    logic          has;
    logic [SB-1:0] smp;
    logic [SB-1:0] lo;
    logic [SB-1:0] hi;
    logic [1:0]    grp;
    logic          last;
  } pixel_beat_t;

  typedef struct packed {
    logic [FB:0] left;
    logic [FB:0] center;
    logic [FB:0] right;
  } levels_t;

  typedef struct packed {
    pixel_beat_t beat;
    logic        typed;
    levels_t     lv;
  } table_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  logic          has_sample_i;
  logic [SB-1:0] sample_i;
  logic [SB-1:0] low_ref_i;
  logic [SB-1:0] high_ref_i;
  logic [1:0]    group_i;
  logic          last_i;
  logic          valid_o;
  logic [FB:0]   level_left_o;
  logic [FB:0]   level_center_o;
  logic [FB:0]   level_right_o;

  logic [28:0] grp_sum[NUM_GROUPS];
  logic [12:0] grp_cnt[NUM_GROUPS];
  levels_t     pending_levels[$];
  table_row_t  directed_rows[$];

  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned levels_seen = 0;
  int unsigned pixels_sent;
  int unsigned batches_closed;
  bit          quiet;

  normalized_group_level_means #(
    .MAX_GROUP_ITEMS(MAXG),
    .SAMPLE_BITS    (SB),
    .FRAC_BITS      (FB)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .has_sample_i  (has_sample_i),
    .sample_i      (sample_i),
    .low_ref_i     (low_ref_i),
    .high_ref_i    (high_ref_i),
    .group_i       (group_i),
    .last_i        (last_i),
    .valid_o       (valid_o),
    .level_left_o  (level_left_o),
    .level_center_o(level_center_o),
    .level_right_o (level_right_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("Timed out after %0d cycles with %0d levels outstanding.",
               cycle_cnt, pending_levels.size());
      $display("[normalized_group_level_means] ERROR");
      $finish;
    end
  end

  function automatic logic [FB:0] clamped_ratio(logic [SB-1:0] s, logic [SB-1:0] lo,
                                                logic [SB-1:0] hi);
    longint span;
    longint num;
    span = longint'($signed(hi)) - longint'($signed(lo));
    num  = longint'($signed(s)) - longint'($signed(lo));
    if (span <= 0 || num <= 0) return '0;
    if (num >= span) return ONE;
    return (FB+1)'((num << FB) / span);
  endfunction

  task automatic take_beat(input pixel_beat_t b, output bit emits, output levels_t lv);
    logic [FB:0] mean[NUM_GROUPS];
    if (b.has && b.grp != GRP_UNUSED && grp_cnt[b.grp] < MAXG) begin
      grp_sum[b.grp] = grp_sum[b.grp] + 29'(clamped_ratio(b.smp, b.lo, b.hi));
      grp_cnt[b.grp] = grp_cnt[b.grp] + 1'b1;
    end
    emits = b.last;
    lv    = '0;
    if (b.last) begin
      for (int k = 0; k < NUM_GROUPS; k++) begin
        mean[k] = (grp_cnt[k] == 0) ? '0 : (FB+1)'(grp_sum[k] / grp_cnt[k]);
        grp_sum[k] = '0;
        grp_cnt[k] = '0;
      end
      lv = {mean[0], mean[1], mean[2]};
    end
  endtask

  // Presents one beat, with a random gap before it unless quiet is set, and waits until busy falls.
  task automatic issue(input pixel_beat_t b, input bit typed, input levels_t typed_lv);
    bit      emits;
    levels_t lv;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    has_sample_i <= b.has;
    sample_i     <= b.smp;
    low_ref_i    <= b.lo;
    high_ref_i   <= b.hi;
    group_i      <= b.grp;
    last_i       <= b.last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    take_beat(b, emits, lv);
    if (b.has) pixels_sent++;
    if (emits) begin
      pending_levels.push_back(typed ? typed_lv : lv);
      batches_closed++;
    end
  endtask

  function automatic pixel_beat_t pixel(logic has, logic [SB-1:0] s, logic [SB-1:0] lo,
                                        logic [SB-1:0] hi, logic [1:0] g, logic last);
    pixel_beat_t b;
    b.has  = has;
    b.smp  = s;
    b.lo   = lo;
    b.hi   = hi;
    b.grp  = g;
    b.last = last;
    return b;
  endfunction

  function automatic logic [SB-1:0] edge_value();
    case ($urandom_range(4))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return '1;
      default: return SB'(1);
    endcase
  endfunction

  function automatic pixel_beat_t random_pixel(logic [1:0] g, logic last);
    pixel_beat_t b;
    longint      lo_v;
    longint      span;
    b = pixel(1'b1, SB'($urandom), SB'($urandom), SB'($urandom), g, last);
    case ($urandom_range(3))
      0: ;
      1: begin
        lo_v  = longint'($signed(b.lo));
        span  = longint'($urandom_range(1, 24'hFFFFFF)) >> $urandom_range(0, 23);
        if (span == 0) span = 1;
        b.hi  = SB'(lo_v + span);
        b.smp = SB'(lo_v + longint'($urandom) % (span + 1));
      end
      2: begin
        b.lo  = SB'(int'($urandom_range(16)) - 8);
        b.hi  = SB'(int'($urandom_range(16)) - 8);
        b.smp = SB'(int'($urandom_range(16)) - 8);
      end
      default: begin
        b.lo  = edge_value();
        b.hi  = edge_value();
        b.smp = edge_value();
      end
    endcase
    return b;
  endfunction

  function automatic table_row_t row(pixel_beat_t b, logic typed = 1'b0,
                                     logic [FB:0] l = '0, logic [FB:0] c = '0,
                                     logic [FB:0] r = '0);
    table_row_t t;
    t.beat  = b;
    t.typed = typed;
    t.lv    = {l, c, r};
    return t;
  endfunction

  always @(posedge clk_i) begin : level_check
    levels_t     want;
    logic [FB:0] w[NUM_GROUPS];
    logic [FB:0] g[NUM_GROUPS];
    string       fname[NUM_GROUPS];
    fname[0] = "level_left";
    fname[1] = "level_center";
    fname[2] = "level_right";
    if (rst_ni && valid_o) begin
      levels_seen++;
      if (pending_levels.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("Unexpected result beat at cycle %0d: %0d %0d %0d.", cycle_cnt,
                   level_left_o, level_center_o, level_right_o);
      end else begin
        want = pending_levels.pop_front();
        w[0] = want.left;
        w[1] = want.center;
        w[2] = want.right;
        g[0] = level_left_o;
        g[1] = level_center_o;
        g[2] = level_right_o;
        for (int k = 0; k < NUM_GROUPS; k++) begin
          if (g[k] !== w[k]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("Mismatch on %s at cycle %0d: expected %0d, got %0d.", fname[k],
                       cycle_cnt, w[k], g[k]);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned blen;
    int unsigned pick;
    pixel_beat_t b;
    bit          closing;

    pixels_sent    = 0;
    batches_closed = 0;
    quiet          = 1'b0;
    for (int k = 0; k < NUM_GROUPS; k++) begin
      grp_sum[k] = '0;
      grp_cnt[k] = '0;
    end
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    has_sample_i <= 1'b0;
    sample_i     <= '0;
    low_ref_i    <= '0;
    high_ref_i   <= '0;
    group_i      <= '0;
    last_i       <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_rows.push_back(row(pixel(0, '0, '0, '0, GRP_LEFT, 1), 1, 0, 0, 0));
    directed_rows.push_back(row(pixel(0, S_MAX, S_MIN, S_MAX, GRP_UNUSED, 0)));
    directed_rows.push_back(row(pixel(1, S_MAX, S_MIN, S_MAX, GRP_LEFT, 0)));
    directed_rows.push_back(row(pixel(1, SB'(5), SB'(5), SB'(5), GRP_CENTER, 0)));
    directed_rows.push_back(row(pixel(1, S_MIN, '0, SB'(100), GRP_RIGHT, 0)));
    directed_rows.push_back(row(pixel(1, S_MAX, S_MIN, S_MAX, GRP_UNUSED, 1), 1, ONE, 0, 0));
    directed_rows.push_back(row(pixel(1, SB'(1), '0, SB'(3), GRP_LEFT, 0)));
    directed_rows.push_back(row(pixel(1, SB'(2), '0, SB'(3), GRP_CENTER, 0)));
    directed_rows.push_back(row(pixel(1, S_MAX, S_MIN, S_MAX, GRP_RIGHT, 1), 1,
                                17'd21845, 17'd43690, ONE));
    directed_rows.push_back(row(pixel(1, '0, SB'(10), -SB'(10), GRP_LEFT, 0)));
    directed_rows.push_back(row(pixel(1, '1, S_MIN, S_MAX, GRP_LEFT, 0)));
    directed_rows.push_back(row(pixel(1, S_MIN + 1'b1, S_MIN, S_MAX, GRP_LEFT, 0)));
    directed_rows.push_back(row(pixel(1, '0, '1, '0, GRP_CENTER, 0)));
    directed_rows.push_back(row(pixel(1, S_MIN, S_MAX, S_MIN, GRP_RIGHT, 0)));
    directed_rows.push_back(row(pixel(1, S_MIN, S_MIN, S_MAX, GRP_RIGHT, 0)));
    directed_rows.push_back(row(pixel(0, '1, '1, '1, GRP_UNUSED, 1)));
    directed_rows.push_back(row(pixel(1, '1, '0, '1, GRP_UNUSED, 1), 1, 0, 0, 0));
    directed_rows.push_back(row(pixel(0, S_MIN, S_MAX, '0, GRP_UNUSED, 0)));
    directed_rows.push_back(row(pixel(1, SB'(3), '0, SB'(4), GRP_CENTER, 1), 1,
                                0, 17'd49152, 0));
    foreach (directed_rows[i])
      issue(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].lv);

    // Fill the left group to capacity; the beats beyond it must leave the mean at one.
    for (int i = 0; i < MAXG + 3; i++) begin
      if (i % 512 == 0) issue(pixel(1, SB'(1), '0, SB'(2), GRP_CENTER, 0), 0, '0);
      b = (i < MAXG) ? pixel(1, SB'(7), '0, SB'(7), GRP_LEFT, 0)
                     : pixel(1, '0, '0, SB'(7), GRP_LEFT, 0);
      issue(b, 0, '0);
    end
    issue(pixel(1, '0, '0, SB'(7), GRP_LEFT, 1), 0, '0);

    counted = 0;
    while (counted < ITEMS) begin
      blen = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      for (int i = 0; i < blen; i++) begin
        quiet   = (counted >= 300 && counted < 450);
        closing = (i == blen - 1);
        pick    = $urandom_range(99);
        if (pick < 6 && !closing) begin
          b = random_pixel(2'($urandom), 1'b0);
          b.has = 1'b0;
        end else if (pick < 12) begin
          b = random_pixel(GRP_UNUSED, closing);
        end else begin
          b = random_pixel(2'($urandom_range(2)), closing);
          counted++;
        end
        if (closing && $urandom_range(3) == 0) b.has = 1'b0;
        issue(b, 0, '0);
      end
    end
    quiet = 1'b0;
    start <= 1'b0;

    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d pixel beats in %0d batches, including a full left group.",
             pixels_sent, batches_closed);
    $display("Checked %0d result beats; %0d mismatches.", levels_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_levels.size() == 0) begin
      $display("[normalized_group_level_means] OK");
    end else begin
      $display("[normalized_group_level_means] ERROR");
    end
    $finish;
  end

endmodule
